// ===== hw/rtl/bde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// bde_pkg: shared types and constants for the button debounce event block.
// No dependencies; used by bde_core, bde_out_buf, the top level and the checker.

package bde_pkg;

  localparam int unsigned DBT_W   = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CLICK_W = 8;
  localparam int unsigned CIDX_W  = 8;
  localparam int unsigned CDAT_W  = 16;

  localparam logic [TICK_W-1:0]  TICK_MAX  = 16'hFFFF;
  localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE    = 8'd0;
  localparam logic [CIDX_W-1:0] REG_LONG_PRESS  = 8'd1;
  localparam logic [CIDX_W-1:0] REG_CLICK_GAP   = 8'd2;
  localparam logic [CIDX_W-1:0] REG_HOLD_REPEAT = 8'd3;

  // register reset values
  localparam logic [DBT_W-1:0]  DEBOUNCE_RST    = 8'd3;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST  = 16'd200;
  localparam logic [TICK_W-1:0] CLICK_GAP_RST   = 16'd60;
  localparam logic [TICK_W-1:0] HOLD_REPEAT_RST = 16'd20;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LONG    = 3'd3,
    EV_CLICK   = 3'd4,
    EV_HOLD    = 3'd5
  } event_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_PRESSED  = 4'b0010,
    ST_RELEASED = 4'b0100,
    ST_HOLD     = 4'b1000
  } state_t;

  typedef struct packed {
    logic [DBT_W-1:0]  debounce_ticks;
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] click_gap_ticks;
    logic [TICK_W-1:0] hold_repeat_ticks;
  } cfg_t;

  typedef struct packed {
    event_t             event_code;
    logic               event_fired;
    logic [CLICK_W-1:0] click_count;
    logic               stable_level;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bde_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// bde_core: debounce filter, tick/click counters and the event state machine.
// Depends on bde_pkg. Advances one tick per asserted step.

module bde_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           raw_level,
  input  bde_pkg::cfg_t       cfg,
  output bde_pkg::result_t    res
);

  logic                         stable_r, stable_nxt;
  logic [bde_pkg::DBT_W-1:0]    dbc_r, dbc_nxt;
  bde_pkg::state_t              state_r, state_nxt;
  logic [bde_pkg::TICK_W-1:0]   tick_r, tick_nxt;
  logic [bde_pkg::CLICK_W-1:0]  press_r, press_nxt;
  bde_pkg::event_t              last_ev_r, last_ev_nxt;

  logic [bde_pkg::DBT_W-1:0]    dbc_inc;
  logic [bde_pkg::TICK_W-1:0]   tick_up;
  logic [bde_pkg::CLICK_W-1:0]  press_inc;
  logic                         fired;

  assign dbc_inc   = dbc_r + 1'b1;
  assign press_inc = (press_r != bde_pkg::CLICK_MAX) ? press_r + 1'b1 : press_r;

  // debounce: new level only after enough differing ticks in a row
  always_comb begin
    stable_nxt = stable_r;
    dbc_nxt    = '0;
    if (raw_level != stable_r) begin
      if (dbc_inc >= cfg.debounce_ticks) begin
        stable_nxt = raw_level;
      end else begin
        dbc_nxt = dbc_inc;
      end
    end
  end

  assign tick_up = (state_r != bde_pkg::ST_IDLE && tick_r != bde_pkg::TICK_MAX) ?
                   tick_r + 1'b1 : tick_r;

  always_comb begin
    state_nxt   = state_r;
    tick_nxt    = tick_up;
    press_nxt   = press_r;
    last_ev_nxt = last_ev_r;
    fired       = 1'b0;
    unique case (state_r)
      bde_pkg::ST_IDLE: begin
        if (stable_nxt) begin
          last_ev_nxt = bde_pkg::EV_PRESS;
          fired       = 1'b1;
          press_nxt   = press_inc;
          tick_nxt    = '0;
          state_nxt   = bde_pkg::ST_PRESSED;
        end else begin
          last_ev_nxt = bde_pkg::EV_NONE;
        end
      end
      bde_pkg::ST_PRESSED: begin
        if (!stable_nxt) begin
          last_ev_nxt = bde_pkg::EV_RELEASE;
          fired       = 1'b1;
          tick_nxt    = '0;
          state_nxt   = bde_pkg::ST_RELEASED;
        end else if (tick_up >= cfg.long_press_ticks) begin
          last_ev_nxt = bde_pkg::EV_LONG;
          fired       = 1'b1;
          press_nxt   = '0;
          tick_nxt    = '0;
          state_nxt   = bde_pkg::ST_HOLD;
        end
      end
      bde_pkg::ST_RELEASED: begin
        if (stable_nxt) begin
          last_ev_nxt = bde_pkg::EV_PRESS;
          fired       = 1'b1;
          press_nxt   = press_inc;
          tick_nxt    = '0;
          state_nxt   = bde_pkg::ST_PRESSED;
        end else if (tick_up >= cfg.click_gap_ticks) begin
          last_ev_nxt = bde_pkg::EV_CLICK;
          fired       = 1'b1;
          press_nxt   = '0;
          tick_nxt    = '0;
          state_nxt   = bde_pkg::ST_IDLE;
        end
      end
      bde_pkg::ST_HOLD: begin
        if (!stable_nxt) begin
          last_ev_nxt = bde_pkg::EV_RELEASE;
          fired       = 1'b1;
          press_nxt   = '0;
          tick_nxt    = '0;
          state_nxt   = bde_pkg::ST_IDLE;
        end else if (tick_up >= cfg.hold_repeat_ticks) begin
          last_ev_nxt = bde_pkg::EV_HOLD;
          fired       = 1'b1;
          tick_nxt    = '0;
        end
      end
      default: begin
        state_nxt = bde_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r  <= 1'b0;
      dbc_r     <= '0;
      state_r   <= bde_pkg::ST_IDLE;
      tick_r    <= '0;
      press_r   <= '0;
      last_ev_r <= bde_pkg::EV_NONE;
    end else if (step) begin
      stable_r  <= stable_nxt;
      dbc_r     <= dbc_nxt;
      state_r   <= state_nxt;
      tick_r    <= tick_nxt;
      press_r   <= press_nxt;
      last_ev_r <= last_ev_nxt;
    end
  end

  assign res.event_code   = last_ev_nxt;
  assign res.event_fired  = fired;
  assign res.click_count  = press_nxt;
  assign res.stable_level = stable_nxt;

endmodule

`default_nettype wire

// ===== hw/rtl/bde_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// bde_out_buf: output register plus one skid entry for result words.
// Depends on bde_pkg. full is registered and backs up the input side.

module bde_out_buf (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  bde_pkg::result_t  load_data,
  output logic              full,
  output logic              out_valid,
  output bde_pkg::result_t  out_data,
  input  wire logic         out_stall
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  bde_pkg::result_t out_data_r, out_data_nxt;
  bde_pkg::result_t skid_data_r, skid_data_nxt;
  logic             out_free;

  // output slot can take a word this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (load) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = load_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (load) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_event_fsm_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Button debounce and event machine, top level: config registers, core, output buffer.
// Depends on bde_pkg, bde_core and bde_out_buf.
//
// Each input word is one scan tick carrying the raw button level. The block takes
// one tick per clock while in_stall is low and returns exactly one result word per
// tick; the tick's whole update (debounce, counters, state machine) is a single pass
// of logic into the state and output or skid registers. Results sit in an
// output register backed by one skid entry, so in_stall rises only once two result
// words wait on a stalled output. A level change is taken as stable after it has
// differed for debounce_ticks ticks in a row; the machine then gives press, release,
// long press, click (after click_gap_ticks released) and hold events (every
// hold_repeat_ticks after a long press). event_code repeats the last event on quiet
// ticks outside idle (none in idle); event_fired marks a tick that raised one. Config
// writes are always ready and apply from the next tick; unmapped indexes are ignored.

module button_debounce_event_fsm_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // tick input
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_raw_level,
  // result output
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [2:0]                       out_event_code,
  output logic                             out_event_fired,
  output logic [bde_pkg::CLICK_W-1:0]      out_click_count,
  output logic                             out_stable_level,
  // config writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bde_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [bde_pkg::CDAT_W-1:0]  cfg_data
);

  bde_pkg::cfg_t    cfg_r;
  bde_pkg::result_t core_res;
  bde_pkg::result_t buf_res;
  logic             in_accept;
  logic             buf_full;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !buf_full;
  assign in_stall  = buf_full;

  // config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks    <= bde_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ticks  <= bde_pkg::LONG_PRESS_RST;
      cfg_r.click_gap_ticks   <= bde_pkg::CLICK_GAP_RST;
      cfg_r.hold_repeat_ticks <= bde_pkg::HOLD_REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bde_pkg::REG_DEBOUNCE:    cfg_r.debounce_ticks    <= cfg_data[bde_pkg::DBT_W-1:0];
        bde_pkg::REG_LONG_PRESS:  cfg_r.long_press_ticks  <= cfg_data;
        bde_pkg::REG_CLICK_GAP:   cfg_r.click_gap_ticks   <= cfg_data;
        bde_pkg::REG_HOLD_REPEAT: cfg_r.hold_repeat_ticks <= cfg_data;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  bde_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_accept),
    .raw_level (in_raw_level),
    .cfg       (cfg_r),
    .res       (core_res)
  );

  bde_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .load_data (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_data  (buf_res),
    .out_stall (out_stall)
  );

  assign out_event_code   = buf_res.event_code;
  assign out_event_fired  = buf_res.event_fired;
  assign out_click_count  = buf_res.click_count;
  assign out_stable_level = buf_res.stable_level;

endmodule

`default_nettype wire

// ===== hw/rtl/bde_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// bde_checker: port-level assertions for button_debounce_event_fsm_top, and its bind.
// Depends on bde_pkg.

module bde_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [2:0]                  out_event_code,
  input wire logic                        out_event_fired,
  input wire logic [bde_pkg::CLICK_W-1:0] out_click_count,
  input wire logic                        out_stable_level
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code) &&
      $stable(out_event_fired) && $stable(out_click_count) && $stable(out_stable_level))
    else $error("stalled result word changed");

  // skid entry only fills behind a waiting output word
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // every taken tick leaves a result word valid on the output in the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted tick gave no result");

  a_fired_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_fired |-> out_event_code != bde_pkg::EV_NONE)
    else $error("event fired with no event code");

  a_fired_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_fired && out_event_code == bde_pkg::EV_PRESS |-> out_stable_level)
    else $error("press event with released level");

endmodule

bind button_debounce_event_fsm_top bde_checker u_bde_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_code   (out_event_code),
  .out_event_fired  (out_event_fired),
  .out_click_count  (out_click_count),
  .out_stable_level (out_stable_level)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for button_debounce_event_fsm_top; a scripted start, then random
// gestures under three idling mixes, then counter and threshold extremes.
// Depends on bde_pkg and the block's RTL only.

module tb;

  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned SCRIPT_LEN  = 29;
  localparam int unsigned SEG_WORDS   = 45;    // ticks per random config setting
  localparam logic [bde_pkg::CIDX_W-1:0] REG_UNUSED = 8'hFF;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  // One row of the scripted start: a tick (optionally with a typed-in result) or a
  // register write.
  typedef struct packed {
    row_kind_t                    kind;
    logic                         raw;
    logic                         known;
    bde_pkg::result_t             want;
    logic [bde_pkg::CIDX_W-1:0]   idx;
    logic [bde_pkg::CDAT_W-1:0]   val;
  } step_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_raw_level;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [2:0]                    out_event_code;
  logic                          out_event_fired;
  logic [bde_pkg::CLICK_W-1:0]   out_click_count;
  logic                          out_stable_level;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bde_pkg::CIDX_W-1:0]    cfg_index;
  logic [bde_pkg::CDAT_W-1:0]    cfg_data;

  // Button model state, kept in step with the block
  bde_pkg::cfg_t                 knobs;
  logic                          lvl_q;
  logic [bde_pkg::DBT_W-1:0]     bounce_cnt;
  bde_pkg::state_t               fsm;
  logic [bde_pkg::TICK_W-1:0]    tick_cnt;
  logic [bde_pkg::CLICK_W-1:0]   clicks;
  bde_pkg::event_t               last_ev;

  bde_pkg::result_t    pending_results [$];
  bde_pkg::result_t    want_word;
  bde_pkg::result_t    seen_word;
  step_row_t           script [SCRIPT_LEN];

  int unsigned         ticks_sent   = 0;
  int unsigned         words_seen   = 0;
  int unsigned         mismatches   = 0;
  int unsigned         cycle_count  = 0;
  int unsigned         tx_idle_pct  = 0;
  int unsigned         rx_idle_pct  = 0;

  button_debounce_event_fsm_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_level     (in_raw_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_code   (out_event_code),
    .out_event_fired  (out_event_fired),
    .out_click_count  (out_click_count),
    .out_stable_level (out_stable_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit: far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Button model
  // ---------------------------------------------------------------------------

  function automatic void reset_button_model();
    knobs.debounce_ticks    = bde_pkg::DEBOUNCE_RST;
    knobs.long_press_ticks  = bde_pkg::LONG_PRESS_RST;
    knobs.click_gap_ticks   = bde_pkg::CLICK_GAP_RST;
    knobs.hold_repeat_ticks = bde_pkg::HOLD_REPEAT_RST;
    lvl_q      = 1'b0;
    bounce_cnt = '0;
    fsm        = bde_pkg::ST_IDLE;
    tick_cnt   = '0;
    clicks     = '0;
    last_ev    = bde_pkg::EV_NONE;
  endfunction

  function automatic void count_click();
    if (clicks != bde_pkg::CLICK_MAX)
      clicks = clicks + 1'b1;
  endfunction

  // Advances the model by one scan tick and returns the word the block should give.
  function automatic bde_pkg::result_t step_button(input logic raw);
    bde_pkg::result_t r;
    logic             fired;
    fired = 1'b0;

    // debounce: a differing level must persist for debounce_ticks ticks
    if (raw != lvl_q) begin
      bounce_cnt = bounce_cnt + 1'b1;
      if (bounce_cnt >= knobs.debounce_ticks) begin
        lvl_q      = raw;
        bounce_cnt = '0;
      end
    end else begin
      bounce_cnt = '0;
    end

    // tick counter runs, saturating, everywhere except idle
    if (fsm != bde_pkg::ST_IDLE && tick_cnt != bde_pkg::TICK_MAX)
      tick_cnt = tick_cnt + 1'b1;

    case (fsm)
      bde_pkg::ST_IDLE: begin
        if (lvl_q) begin
          last_ev = bde_pkg::EV_PRESS; fired = 1'b1;
          count_click();
          tick_cnt = '0;
          fsm = bde_pkg::ST_PRESSED;
        end else begin
          last_ev = bde_pkg::EV_NONE;
        end
      end
      bde_pkg::ST_PRESSED: begin
        if (!lvl_q) begin
          last_ev = bde_pkg::EV_RELEASE; fired = 1'b1;
          tick_cnt = '0;
          fsm = bde_pkg::ST_RELEASED;
        end else if (tick_cnt >= knobs.long_press_ticks) begin
          last_ev = bde_pkg::EV_LONG; fired = 1'b1;
          clicks = '0;
          tick_cnt = '0;
          fsm = bde_pkg::ST_HOLD;
        end
      end
      bde_pkg::ST_RELEASED: begin
        if (lvl_q) begin
          last_ev = bde_pkg::EV_PRESS; fired = 1'b1;
          count_click();
          tick_cnt = '0;
          fsm = bde_pkg::ST_PRESSED;
        end else if (tick_cnt >= knobs.click_gap_ticks) begin
          last_ev = bde_pkg::EV_CLICK; fired = 1'b1;
          clicks = '0;
          tick_cnt = '0;
          fsm = bde_pkg::ST_IDLE;
        end
      end
      default: begin
        // holding after a long press; the release here ends the sequence
        if (!lvl_q) begin
          last_ev = bde_pkg::EV_RELEASE; fired = 1'b1;
          clicks = '0;
          tick_cnt = '0;
          fsm = bde_pkg::ST_IDLE;
        end else if (tick_cnt >= knobs.hold_repeat_ticks) begin
          last_ev = bde_pkg::EV_HOLD; fired = 1'b1;
          tick_cnt = '0;
        end
      end
    endcase

    r.event_code   = last_ev;
    r.event_fired  = fired;
    r.click_count  = clicks;
    r.stable_level = lvl_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move at the falling edge; every task starts and ends there.
  // ---------------------------------------------------------------------------

  // Offers one tick word, with random sender gaps ahead of it. A typed-in result,
  // where given, replaces the model's word in the queue (the model still steps).
  task automatic send_tick(input logic lvl, input logic known,
                           input bde_pkg::result_t want);
    bde_pkg::result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid     = 1'b0;
      in_raw_level = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_raw_level = lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = step_button(lvl);
    pending_results.push_back(known ? want : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic hold_level(input logic lvl, input int unsigned n);
    repeat (n) send_tick(lvl, 1'b0, '0);
  endtask

  // Sender pauses until every expected word is back, plus a short margin.
  task automatic settle_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bde_pkg::CIDX_W-1:0] idx,
                           input logic [bde_pkg::CDAT_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bde_pkg::REG_DEBOUNCE:    knobs.debounce_ticks    = val[bde_pkg::DBT_W-1:0];
      bde_pkg::REG_LONG_PRESS:  knobs.long_press_ticks  = val;
      bde_pkg::REG_CLICK_GAP:   knobs.click_gap_ticks   = val;
      bde_pkg::REG_HOLD_REPEAT: knobs.hold_repeat_ticks = val;
      default: ;       // unmapped index, ignored
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Timing registers: mostly short so events come often, sometimes zero or full scale.
  function automatic logic [bde_pkg::CDAT_W-1:0] pick_period(input int unsigned hi);
    case ($urandom_range(9))
      0:       return '0;
      1:       return bde_pkg::TICK_MAX;
      default: return bde_pkg::CDAT_W'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic random_setting();
    logic [bde_pkg::CDAT_W-1:0] db;
    case ($urandom_range(9))
      0:       db = '0;
      1:       db = 16'h00FF;
      default: db = bde_pkg::CDAT_W'($urandom_range(1, 4));
    endcase
    db[bde_pkg::CDAT_W-1:bde_pkg::DBT_W] = 8'($urandom_range(255));   // upper byte is don't-care
    settle_idle();
    write_reg(bde_pkg::REG_DEBOUNCE, db);
    write_reg(bde_pkg::REG_LONG_PRESS, pick_period(40));
    write_reg(bde_pkg::REG_CLICK_GAP, pick_period(30));
    write_reg(bde_pkg::REG_HOLD_REPEAT, pick_period(10));
  endtask

  // One random gesture: mostly bouncy press/release pairs, some noise, some long
  // holds and long quiet spells.
  task automatic play_gesture();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      repeat ($urandom_range(3)) send_tick(1'($urandom_range(1)), 1'b0, '0);
      hold_level(1'b1, $urandom_range(1, 50));
      repeat ($urandom_range(3)) send_tick(1'($urandom_range(1)), 1'b0, '0);
      hold_level(1'b0, $urandom_range(1, 40));
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(1)), 1'b0, '0);
    end else if (kind == 8) begin
      hold_level(1'b1, $urandom_range(40, 120));
    end else begin
      hold_level(1'b0, $urandom_range(30, 100));
    end
  endtask

  // Receiver stalls at random, per the current mix.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < rx_idle_pct);

  // ---------------------------------------------------------------------------
  // Result checker: each accepted word against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_word = '{bde_pkg::event_t'(out_event_code), out_event_fired, out_click_count,
                    out_stable_level};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d arrived with nothing expected: ev=%0d fired=%0b clicks=%0d lvl=%0b",
                   words_seen, seen_word.event_code, seen_word.event_fired,
                   seen_word.click_count, seen_word.stable_level);
      end else begin
        want_word = pending_results.pop_front();
        if (seen_word !== want_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word %0d: expected ev=%0d fired=%0b clicks=%0d lvl=%0b, ",
                      "got ev=%0d fired=%0b clicks=%0d lvl=%0b"},
                     words_seen, want_word.event_code, want_word.event_fired,
                     want_word.click_count, want_word.stable_level,
                     seen_word.event_code, seen_word.event_fired,
                     seen_word.click_count, seen_word.stable_level);
        end
      end
      words_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic step_row_t tick_row(input logic raw);
    step_row_t r;
    r      = '0;
    r.kind = ROW_TICK;
    r.raw  = raw;
    return r;
  endfunction

  function automatic step_row_t tick_known(input logic raw, input bde_pkg::event_t ev,
                                           input logic fired, input logic [7:0] cnt,
                                           input logic lvl);
    step_row_t r;
    r       = tick_row(raw);
    r.known = 1'b1;
    r.want  = '{ev, fired, cnt, lvl};
    return r;
  endfunction

  function automatic step_row_t reg_row(input logic [bde_pkg::CIDX_W-1:0] idx,
                                        input logic [bde_pkg::CDAT_W-1:0] val);
    step_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_raw_level = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    reset_button_model();

    script = '{
      // reset settings, debounce of three
      tick_known(1'b0, bde_pkg::EV_NONE, 1'b0, 8'd0, 1'b0),
      tick_row(1'b1), tick_row(1'b1),
      tick_known(1'b1, bde_pkg::EV_PRESS, 1'b1, 8'd1, 1'b1),
      tick_row(1'b0),
      tick_row(1'b1),                                 // glitch restarts the debounce
      tick_row(1'b0), tick_row(1'b0), tick_row(1'b0), // release
      // zero debounce and zero hold period, short long-press and click gap
      reg_row(bde_pkg::REG_DEBOUNCE, 16'd0),
      reg_row(bde_pkg::REG_LONG_PRESS, 16'd3),
      reg_row(bde_pkg::REG_CLICK_GAP, 16'd2),
      reg_row(bde_pkg::REG_HOLD_REPEAT, 16'd0),
      tick_row(1'b0), tick_row(1'b0),                 // click after the gap
      tick_row(1'b0),                                 // idle: event goes back to none
      tick_known(1'b1, bde_pkg::EV_PRESS, 1'b1, 8'd1, 1'b1),   // taken at once
      tick_row(1'b1), tick_row(1'b1), tick_row(1'b1), // long press clears the count
      tick_row(1'b1), tick_row(1'b1),                 // hold repeats every tick
      tick_row(1'b0),                                 // release ending the hold
      tick_row(1'b1), tick_row(1'b0),                 // double click
      tick_row(1'b1), tick_row(1'b0),
      tick_row(1'b0), tick_row(1'b0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // scripted start under the first idling mix
    tx_idle_pct = 9;
    rx_idle_pct = 46;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle_idle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_tick(script[i].raw, script[i].known, script[i].want);
      end
    end

    // random gestures: sender 9 / receiver 46, then swapped, then no idling
    for (int mix = 0; mix < 3; mix++) begin
      tx_idle_pct = (mix == 0) ? 9  : (mix == 1) ? 46 : 0;
      rx_idle_pct = (mix == 0) ? 46 : (mix == 1) ? 9  : 0;
      for (int seg = 0; seg < 3; seg++) begin
        int unsigned stop_at;
        random_setting();
        stop_at = ticks_sent + SEG_WORDS;
        while (ticks_sent < stop_at) play_gesture();
      end
    end

    // extremes, no idling: longest debounce and full-scale timers
    settle_idle();
    write_reg(bde_pkg::REG_DEBOUNCE, 16'd255);
    write_reg(bde_pkg::REG_LONG_PRESS, bde_pkg::TICK_MAX);
    write_reg(bde_pkg::REG_CLICK_GAP, bde_pkg::TICK_MAX);
    write_reg(bde_pkg::REG_HOLD_REPEAT, bde_pkg::TICK_MAX);
    write_reg(REG_UNUSED, 16'hA5A5);
    hold_level(1'b1, 254);
    hold_level(1'b0, 1);
    hold_level(1'b1, 255);

    // click count saturates
    settle_idle();
    write_reg(bde_pkg::REG_DEBOUNCE, 16'd0);
    repeat (260) begin
      send_tick(1'b1, 1'b0, '0);
      send_tick(1'b0, 1'b0, '0);
    end
    hold_level(1'b0, 4);

    // drain, then a short margin for anything unexpected
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== button_debounce_event_fsm_top.f =====
hw/rtl/bde_pkg.sv
hw/rtl/bde_core.sv
hw/rtl/bde_out_buf.sv
hw/rtl/button_debounce_event_fsm_top.sv
hw/rtl/bde_checker.sv
tb/tb.sv
